// ----- rtl/core/fts_pkg.sv -----
// ----------------------------------------------------------------------------
// fts_pkg
// Shared widths, register indexes, reset values and the command and status
// bundles passed between the frame timestamp smoother controller and datapath.
// ----------------------------------------------------------------------------
package fts_pkg;

	localparam int TIME_W     = 63;
	localparam int COUNT_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int GAIN_W     = 16;

	localparam logic [31:0] RST_INITIAL_PERIOD   = 32'd141733920;
	localparam logic [15:0] RST_PERIOD_GAIN      = 16'd655;
	localparam logic [31:0] RST_RESET_WINDOW     = 32'd858993459;
	localparam logic [15:0] RST_CORRECTION_GAIN  = 16'd6554;
	localparam logic [31:0] RST_CORRECTION_LIMIT = 32'd4294967;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INITIAL_PERIOD   = 3'd0,
		CFG_PERIOD_GAIN      = 3'd1,
		CFG_RESET_WINDOW     = 3'd2,
		CFG_CORRECTION_GAIN  = 3'd3,
		CFG_CORRECTION_LIMIT = 3'd4
	} cfg_idx_t;

	// second multiplier operand
	typedef enum logic [1:0] {
		MSEL_PGAIN = 2'd0,
		MSEL_DC    = 2'd1,
		MSEL_CGAIN = 2'd2
	} msel_t;

	typedef struct packed {
		logic  load;     // latch request, start divider
		logic  err;      // period error against estimate
		logic  mul_lo;   // low-half partial product
		logic  mul_hi;   // high-half partial product
		logic  mul_sum;  // combine partial products
		msel_t msel;
		logic  est;      // estimate update, load |next_period|
		logic  adv;      // advance clock
		logic  drift;    // drift and snap test
		logic  corr;     // clamped correction into next period
		logic  commit;   // update state, load output register
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} status_t;

endpackage

// ----- rtl/core/fts_if.sv -----
// ----------------------------------------------------------------------------
// fts_if
// Handshake channels of the frame timestamp smoother: sample requests,
// result requests and register writes.
// ----------------------------------------------------------------------------
interface fts_sample_if;
	logic        valid;
	logic        ready;
	logic [62:0] raw_time;
	logic [31:0] frame_count;

	modport source (output valid, output raw_time, output frame_count, input ready);
	modport sink   (input valid, input raw_time, input frame_count, output ready);
endinterface

interface fts_result_if;
	logic        valid;
	logic        ready;
	logic [62:0] smoothed_time;
	logic        clock_snapped;

	modport source (output valid, output smoothed_time, output clock_snapped, input ready);
	modport sink   (input valid, input smoothed_time, input clock_snapped, output ready);
endinterface

interface fts_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/frame_timestamp_smoother.sv -----
// ----------------------------------------------------------------------------
// frame_timestamp_smoother
// Smooths jittery frame timestamps with an adaptive period estimate, a
// clamped drift correction and a snap to raw time past the reset window.
// ----------------------------------------------------------------------------
//  channel  dir  payload                           request moves when
//  sample   in   raw_time[62:0], frame_count[31:0] valid & ready
//  result   out  smoothed_time[62:0], clock_snapped valid & ready
//  cfg      in   index[2:0], data[31:0]            valid & ready (ready tied high)
//
//  One request at a time runs from acceptance to result through the
//  bit-per-cycle period divider, three two-pass products on one shared
//  32x32 multiplier and the update steps.
//  A finished result waits in the output register; the next request is taken
//  meanwhile, and its commit waits only if that result is still untaken.
//  Reset loads the register defaults and clears the clock and count; no sweep.
// ----------------------------------------------------------------------------
module frame_timestamp_smoother (
	input  logic         clk,
	input  logic         arst_n,
	fts_sample_if.sink   sample,
	fts_result_if.source result,
	fts_cfg_if.sink      cfg
);
	import fts_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg.ready = 1'b1;

	fts_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample.valid),
		.sample_ready (sample.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.status       (status),
		.cmd          (cmd)
	);

	fts_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.raw_time      (sample.raw_time),
		.frame_count   (sample.frame_count),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.smoothed_time (result.smoothed_time),
		.clock_snapped (result.clock_snapped)
	);

endmodule

// ----- rtl/core/fts_divider.sv -----
// ----------------------------------------------------------------------------
// fts_divider
// Radix-2 restoring divider: time span magnitude by frame count delta,
// one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module fts_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fts_pkg::TIME_W-1:0]  dividend,
	input  logic [fts_pkg::COUNT_W-1:0] divisor,
	output logic [fts_pkg::TIME_W-1:0]  quotient,
	output logic                       done
);
	import fts_pkg::*;

	localparam int CNT_W = $clog2(TIME_W);

	logic [TIME_W-1:0]  quo_q;
	logic [COUNT_W-1:0] rem_q;
	logic [COUNT_W-1:0] div_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [COUNT_W:0]   shifted;
	logic               fits;

	assign shifted = {rem_q, quo_q[TIME_W-1]};
	assign fits    = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(TIME_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= COUNT_W'(shifted - {1'b0, div_q});
			end else begin
				rem_q <= shifted[COUNT_W-1:0];
			end
			quo_q <= {quo_q[TIME_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ----- rtl/core/fts_datapath.sv -----
// ----------------------------------------------------------------------------
// fts_datapath
// Registers, period divider, shared 32x32 multiplier and the saturating
// arithmetic of the frame timestamp smoother. Sequenced by fts_ctrl.
// ----------------------------------------------------------------------------
module fts_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fts_pkg::cmd_t                 cmd,
	output fts_pkg::status_t              status,
	input  logic [fts_pkg::TIME_W-1:0]     raw_time,
	input  logic [fts_pkg::COUNT_W-1:0]    frame_count,
	input  logic                          cfg_we,
	input  logic [fts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fts_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic [fts_pkg::TIME_W-1:0]     smoothed_time,
	output logic                          clock_snapped
);
	import fts_pkg::*;

	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
	localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) sat_add = s[64] ? S64_MIN : S64_MAX;
		else sat_add = s[63:0];
	endfunction

	function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) sat_sub = s[64] ? S64_MIN : S64_MAX;
		else sat_sub = s[63:0];
	endfunction

	function automatic logic [63:0] abs64(input logic [63:0] v);
		abs64 = v[63] ? (64'd0 - v) : v;
	endfunction

	// configuration
	logic [GAIN_W-1:0]  pgain_q;
	logic [31:0]        window_q;
	logic [GAIN_W-1:0]  cgain_q;
	logic [31:0]        climit_q;

	// smoother state
	logic [TIME_W-1:0]  last_time_q;
	logic [COUNT_W-1:0] last_count_q;
	logic [63:0]        est_q;
	logic [63:0]        next_q;

	// per-request working registers
	logic [TIME_W-1:0]  raw_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] dc_q;
	logic               span_neg_q;
	logic [63:0]        mag_q;
	logic               neg_q;
	logic [63:0]        mul_q;
	logic [63:0]        lo_q;
	logic [95:0]        sum_q;
	logic [63:0]        est_new_q;
	logic [63:0]        next_new_q;
	logic [TIME_W-1:0]  clock_q;
	logic               snap_q;
	logic [TIME_W-1:0]  out_time_q;
	logic               out_snap_q;

	logic [COUNT_W-1:0] dc_raw;
	logic [COUNT_W-1:0] dc_load;
	logic [63:0]        span;
	logic [TIME_W-1:0]  span_mag;
	logic [TIME_W-1:0]  quo;
	logic               div_done;

	logic [63:0]        period;
	logic [63:0]        err_val;
	logic [31:0]        opa;
	logic [31:0]        opb;
	logic [TIME_W-1:0]  gmag;
	logic [63:0]        gval;
	logic [63:0]        cmag_neg;
	logic [TIME_W-1:0]  cmag_pos;
	logic [64:0]        sum_neg;
	logic [63:0]        sum_pos;
	logic [TIME_W-1:0]  clock_new;
	logic [63:0]        drift;
	logic [63:0]        drift_mag;
	logic [31:0]        corr_mag;
	logic [63:0]        corr_val;

	// zero count delta counts as one
	assign dc_raw   = frame_count - last_count_q;
	assign dc_load  = (dc_raw == '0) ? COUNT_W'(1) : dc_raw;
	assign span     = {1'b0, raw_time} - {1'b0, last_time_q};
	assign span_mag = TIME_W'(abs64(span));

	fts_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.dividend (span_mag),
		.divisor  (dc_load),
		.quotient (quo),
		.done     (div_done)
	);

	assign status.div_done = div_done;

	assign period  = span_neg_q ? (64'd0 - {1'b0, quo}) : {1'b0, quo};
	assign err_val = sat_sub(period, est_q);

	assign opa = cmd.mul_hi ? mag_q[63:32] : mag_q[31:0];
	always_comb begin
		case (cmd.msel)
			MSEL_PGAIN: opb = {16'd0, pgain_q};
			MSEL_DC:    opb = dc_q;
			MSEL_CGAIN: opb = {16'd0, cgain_q};
			default:    opb = '0;
		endcase
	end

	// Q0.16 gain product, truncated toward zero on the magnitude
	assign gmag = sum_q[TIME_W+15:16];
	assign gval = neg_q ? (64'd0 - {1'b0, gmag}) : {1'b0, gmag};

	// clock advance: magnitude clipped before the add, clock held in [0, T_MAX]
	assign cmag_neg  = ((|sum_q[95:64]) || (sum_q[63] && (|sum_q[62:0]))) ? S64_MIN
		: sum_q[63:0];
	assign cmag_pos  = (|sum_q[95:63]) ? T_MAX : sum_q[62:0];
	assign sum_neg   = {2'b00, last_time_q} - {1'b0, cmag_neg};
	assign sum_pos   = {1'b0, last_time_q} + {1'b0, cmag_pos};
	always_comb begin
		if (neg_q) clock_new = sum_neg[64] ? '0 : sum_neg[TIME_W-1:0];
		else clock_new = sum_pos[63] ? T_MAX : sum_pos[TIME_W-1:0];
	end

	assign drift     = {1'b0, raw_q} - {1'b0, clock_q};
	assign drift_mag = abs64(drift);

	assign corr_mag = (gmag > {31'd0, climit_q}) ? climit_q : gmag[31:0];
	assign corr_val = neg_q ? (64'd0 - {32'd0, corr_mag}) : {32'd0, corr_mag};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pgain_q       <= RST_PERIOD_GAIN;
			window_q      <= RST_RESET_WINDOW;
			cgain_q       <= RST_CORRECTION_GAIN;
			climit_q      <= RST_CORRECTION_LIMIT;
			last_time_q   <= '0;
			last_count_q  <= '0;
			est_q         <= {32'd0, RST_INITIAL_PERIOD};
			next_q        <= {32'd0, RST_INITIAL_PERIOD};
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_INITIAL_PERIOD: begin
						est_q         <= {32'd0, cfg_data};
						next_q        <= {32'd0, cfg_data};
					end
					CFG_PERIOD_GAIN:      pgain_q  <= cfg_data[GAIN_W-1:0];
					CFG_RESET_WINDOW:     window_q <= cfg_data;
					CFG_CORRECTION_GAIN:  cgain_q  <= cfg_data[GAIN_W-1:0];
					CFG_CORRECTION_LIMIT: climit_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.commit) begin
				last_count_q <= count_q;
				if (snap_q) begin
					// estimate step undone, clock snaps to raw time
					next_q      <= est_q;
					last_time_q <= raw_q;
				end else begin
					est_q       <= est_new_q;
					next_q      <= next_new_q;
					last_time_q <= clock_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q      <= raw_time;
			count_q    <= frame_count;
			dc_q       <= dc_load;
			span_neg_q <= span[63];
		end
		if (cmd.err) begin
			mag_q <= abs64(err_val);
			neg_q <= err_val[63];
		end
		if (cmd.mul_lo || cmd.mul_hi) begin
			mul_q <= opa * opb;
		end
		if (cmd.mul_hi) begin
			lo_q <= mul_q;
		end
		if (cmd.mul_sum) begin
			sum_q <= {mul_q, 32'd0} + {32'd0, lo_q};
		end
		if (cmd.est) begin
			est_new_q <= sat_add(est_q, gval);
			mag_q     <= abs64(next_q);
			neg_q     <= next_q[63];
		end
		if (cmd.adv) begin
			clock_q <= clock_new;
		end
		if (cmd.drift) begin
			mag_q  <= drift_mag;
			neg_q  <= drift[63];
			snap_q <= drift_mag > {32'd0, window_q};
		end
		if (cmd.corr) begin
			next_new_q <= sat_add(est_new_q, corr_val);
		end
		if (cmd.commit) begin
			out_time_q <= snap_q ? raw_q : clock_q;
			out_snap_q <= snap_q;
		end
	end

	assign smoothed_time = out_time_q;
	assign clock_snapped = out_snap_q;

endmodule

// ----- rtl/core/fts_ctrl.sv -----
// ----------------------------------------------------------------------------
// fts_ctrl
// Sequencer of the frame timestamp smoother: accepts a request, runs the
// divide, the three two-pass products and the updates, then commits.
// ----------------------------------------------------------------------------
module fts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_ready,
	output logic             result_valid,
	input  logic             result_ready,
	input  fts_pkg::status_t status,
	output fts_pkg::cmd_t    cmd
);
	import fts_pkg::*;

	typedef enum logic [16:0] {
		S_IDLE  = 17'b00000000000000001,
		S_DIV   = 17'b00000000000000010,
		S_ERR   = 17'b00000000000000100,
		S_GL    = 17'b00000000000001000,
		S_GH    = 17'b00000000000010000,
		S_GS    = 17'b00000000000100000,
		S_EST   = 17'b00000000001000000,
		S_AL    = 17'b00000000010000000,
		S_AH    = 17'b00000000100000000,
		S_AS    = 17'b00000001000000000,
		S_ADV   = 17'b00000010000000000,
		S_DRIFT = 17'b00000100000000000,
		S_CL    = 17'b00001000000000000,
		S_CH    = 17'b00010000000000000,
		S_CS    = 17'b00100000000000000,
		S_CORR  = 17'b01000000000000000,
		S_WB    = 17'b10000000000000000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free    = !out_valid_q || result_ready;
	assign sample_ready = (state_q == S_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.msel  = MSEL_PGAIN;
		case (state_q)
			S_IDLE: begin
				if (sample_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_DIV;
				end
			end
			S_DIV:   if (status.div_done) state_nxt = S_ERR;
			S_ERR: begin
				cmd.err   = 1'b1;
				state_nxt = S_GL;
			end
			S_GL: begin
				cmd.mul_lo = 1'b1;
				state_nxt  = S_GH;
			end
			S_GH: begin
				cmd.mul_hi = 1'b1;
				state_nxt  = S_GS;
			end
			S_GS: begin
				cmd.mul_sum = 1'b1;
				state_nxt   = S_EST;
			end
			S_EST: begin
				cmd.est   = 1'b1;
				state_nxt = S_AL;
			end
			S_AL: begin
				cmd.msel   = MSEL_DC;
				cmd.mul_lo = 1'b1;
				state_nxt  = S_AH;
			end
			S_AH: begin
				cmd.msel   = MSEL_DC;
				cmd.mul_hi = 1'b1;
				state_nxt  = S_AS;
			end
			S_AS: begin
				cmd.mul_sum = 1'b1;
				state_nxt   = S_ADV;
			end
			S_ADV: begin
				cmd.adv   = 1'b1;
				state_nxt = S_DRIFT;
			end
			S_DRIFT: begin
				cmd.drift = 1'b1;
				state_nxt = S_CL;
			end
			// correction product is computed on a snap too, then discarded
			S_CL: begin
				cmd.msel   = MSEL_CGAIN;
				cmd.mul_lo = 1'b1;
				state_nxt  = S_CH;
			end
			S_CH: begin
				cmd.msel   = MSEL_CGAIN;
				cmd.mul_hi = 1'b1;
				state_nxt  = S_CS;
			end
			S_CS: begin
				cmd.mul_sum = 1'b1;
				state_nxt   = S_CORR;
			end
			S_CORR: begin
				cmd.corr  = 1'b1;
				state_nxt = S_WB;
			end
			S_WB: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
		end
	end

endmodule
